>>> sv/nofi_pkg.sv
package nofi_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int ID_BITS_DEF     = 64;
   localparam int OBS_KEEP_MS     = 500;
   localparam int IGN_KEEP_MS     = 10000;

   localparam int TIME_BITS  = 32;
   localparam int REG_BITS   = 16;
   localparam int IDX_BITS   = 2;
   localparam int OBJ_ID_BITS = 64;
   localparam int POS_BITS   = 24;
   localparam int CLASS_BITS = 4;

   localparam logic [IDX_BITS-1:0] CSR_RADIUS = 2'd0;
   localparam logic [IDX_BITS-1:0] CSR_KEEP   = 2'd1;
   localparam logic [IDX_BITS-1:0] CSR_MASK   = 2'd2;

   localparam logic CMD_FRAME  = 1'b0;
   localparam logic CMD_OBJECT = 1'b1;

   // control broadcast from the sequencer to every cell of a table
   typedef struct packed {
      logic look;
      logic go;
      logic age;
      logic refresh;
      logic insert;
   } tbl_ctrl_type;

   // priority chain between neighboring cells, last link is the table status
   typedef struct packed {
      logic hit;
      logic free;
      logic young;
   } link_type;

endpackage

>>> sv/nofi_cell.sv
module nofi_cell import nofi_pkg::*; #(
   parameter int ID_BITS = ID_BITS_DEF,
   parameter int KEEP_MS = OBS_KEEP_MS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tbl_ctrl_type         ctrl,
   input  logic [ID_BITS-1:0]   key,
   input  logic [TIME_BITS-1:0] now,
   input  logic [REG_BITS-1:0]  keep_ms,
   input  link_type             link_in,
   output link_type             link_out
);

   logic                 valid_ff, valid_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TIME_BITS-1:0] stamp_ff, stamp_in;
   logic                 match_ff, match_in;
   logic                 young_ff, young_in;
   logic [TIME_BITS-1:0] age;
   logic                 sel_hit;
   logic                 sel_free;
   logic                 expired;

   assign age      = now - stamp_ff;
   assign sel_hit  = match_ff & ~link_in.hit;
   assign sel_free = ~valid_ff & ~link_in.free;
   assign expired  = ~age[TIME_BITS-1] & (age[TIME_BITS-2:0] > (TIME_BITS-1)'(KEEP_MS));

   assign link_out.hit   = link_in.hit | match_ff;
   assign link_out.free  = link_in.free | ~valid_ff;
   assign link_out.young = link_in.hit ? link_in.young : (match_ff & young_ff);

   always_comb begin
      match_in = match_ff;
      young_in = young_ff;
      valid_in = valid_ff;
      id_in    = id_ff;
      stamp_in = stamp_ff;
      if (ctrl.look) begin
         match_in = valid_ff && (id_ff == key);
         young_in = age[TIME_BITS-1] || (age < {{(TIME_BITS-REG_BITS){1'b0}}, keep_ms});
      end
      if (ctrl.go) begin
         if (ctrl.age) begin
            if (valid_ff && expired) begin
               valid_in = 1'b0;
            end
         end else begin
            if (ctrl.refresh && sel_hit) begin
               stamp_in = now;
            end
            if (ctrl.insert && sel_free) begin
               valid_in = 1'b1;
               id_in    = key;
               stamp_in = now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         young_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         young_ff <= young_in;
      end
      id_ff    <= id_in;
      stamp_ff <= stamp_in;
   end

endmodule

>>> sv/nofi_table.sv
module nofi_table import nofi_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ID_BITS     = ID_BITS_DEF,
   parameter int KEEP_MS     = OBS_KEEP_MS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tbl_ctrl_type         ctrl,
   input  logic [ID_BITS-1:0]   key,
   input  logic [TIME_BITS-1:0] now,
   input  logic [REG_BITS-1:0]  keep_ms,
   output link_type             status
);

   link_type links [TABLE_DEPTH+1];

   assign links[0] = '0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      nofi_cell #(
         .ID_BITS (ID_BITS),
         .KEEP_MS (KEEP_MS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .key      (key),
         .now      (now),
         .keep_ms  (keep_ms),
         .link_in  (links[i]),
         .link_out (links[i+1])
      );
   end

   assign status = links[TABLE_DEPTH];

endmodule

>>> sv/nearby_object_ignore_filter_core.sv
// channel   prefix  direction  handshake      payload
// request   req_    in         valid / stall  cmd, time_ms, track_id, pos_x_mm, pos_y_mm,
//                                             class_label
// response  rsp_    out        valid / stall  passed, newly_ignored, table_overflow
// config    csr_    in         write enable   index, 16-bit data
//
// each item passes a compare state, to compare every table cell and square the position, and
// a decide state, to resolve the cell priority chains, update the tables and register the result.
// a frame start ages both tables in its decide state.
// synchronous active-high reset empties both tables at once, no clearing pass.
// a waiting result holds the decide state, and with it the next item, while rsp_stall is high.
module nearby_object_ignore_filter_core import nofi_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ID_BITS     = ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [TIME_BITS-1:0]         req_time_ms,
   input  logic [OBJ_ID_BITS-1:0]       req_track_id,
   input  logic signed [POS_BITS-1:0]   req_pos_x_mm,
   input  logic signed [POS_BITS-1:0]   req_pos_y_mm,
   input  logic [CLASS_BITS-1:0]        req_class_label,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_passed,
   output logic                         rsp_newly_ignored,
   output logic                         rsp_table_overflow,
   input  logic                         csr_we,
   input  logic [IDX_BITS-1:0]          csr_index,
   input  logic [REG_BITS-1:0]          csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOK   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   localparam int SQ_BITS = 2 * POS_BITS;

   logic [1:0]                state_ff, state_in;
   logic [REG_BITS-1:0]       radius_ff, keep_ms_ff, mask_ff;
   logic [TIME_BITS-1:0]      current_time_ff;
   logic                      item_cmd_ff;
   logic [ID_BITS-1:0]        item_id_ff;
   logic signed [POS_BITS-1:0] item_x_ff, item_y_ff;
   logic [CLASS_BITS-1:0]     item_cls_ff;
   logic [SQ_BITS-1:0]        xsq_ff, ysq_ff;
   logic [2*REG_BITS-1:0]     rsq_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_passed_ff, rsp_newly_ff, rsp_over_ff;

   logic signed [SQ_BITS-1:0] xsq_full, ysq_full;
   logic [SQ_BITS:0]          dist2;
   logic                      accept;
   logic                      go;
   logic                      is_obj;
   logic                      cand;
   logic                      ign_insert;
   logic                      res_passed, res_newly, res_over;
   tbl_ctrl_type              obs_ctrl, ign_ctrl;
   link_type                  obs_status, ign_status;

   assign accept = req_valid & ~req_stall;
   assign go     = (state_ff == ST_DECIDE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !((state_ff == ST_IDLE) || go);
   assign is_obj = (item_cmd_ff == CMD_OBJECT);

   assign xsq_full = SQ_BITS'(item_x_ff) * SQ_BITS'(item_x_ff);
   assign ysq_full = SQ_BITS'(item_y_ff) * SQ_BITS'(item_y_ff);
   assign dist2    = {1'b0, xsq_ff} + {1'b0, ysq_ff};
   assign cand     = (dist2 <= {{(SQ_BITS+1-2*REG_BITS){1'b0}}, rsq_ff}) && mask_ff[item_cls_ff];

   assign ign_insert = is_obj & cand & ~ign_status.young & ~obs_status.hit;

   always_comb begin
      obs_ctrl.look    = (state_ff == ST_LOOK);
      obs_ctrl.go      = go;
      obs_ctrl.age     = ~is_obj;
      obs_ctrl.refresh = is_obj;
      obs_ctrl.insert  = is_obj & ~obs_status.hit;
      ign_ctrl.look    = (state_ff == ST_LOOK);
      ign_ctrl.go      = go;
      ign_ctrl.age     = ~is_obj;
      ign_ctrl.refresh = 1'b0;
      ign_ctrl.insert  = ign_insert;
   end

   assign res_passed = is_obj & (~cand | (~ign_status.young & obs_status.hit));
   assign res_newly  = ign_insert & ign_status.free;
   assign res_over   = is_obj & ((~obs_status.hit & ~obs_status.free)
                               | (ign_insert & ~ign_status.free));

   nofi_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (ID_BITS),
      .KEEP_MS     (OBS_KEEP_MS)
   ) u_observed (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (obs_ctrl),
      .key     (item_id_ff),
      .now     (current_time_ff),
      .keep_ms (keep_ms_ff),
      .status  (obs_status)
   );

   nofi_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (ID_BITS),
      .KEEP_MS     (IGN_KEEP_MS)
   ) u_ignored (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ign_ctrl),
      .key     (item_id_ff),
      .now     (current_time_ff),
      .keep_ms (keep_ms_ff),
      .status  (ign_status)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (go) begin
               state_in = accept ? ST_LOOK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         current_time_ff <= '0;
         radius_ff       <= '0;
         keep_ms_ff      <= '0;
         mask_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && (req_cmd == CMD_FRAME)) begin
            current_time_ff <= req_time_ms;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_RADIUS: radius_ff  <= csr_wdata;
               CSR_KEEP:   keep_ms_ff <= csr_wdata;
               CSR_MASK:   mask_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_cmd_ff <= req_cmd;
         item_id_ff  <= req_track_id[ID_BITS-1:0];
         item_x_ff   <= req_pos_x_mm;
         item_y_ff   <= req_pos_y_mm;
         item_cls_ff <= req_class_label;
      end
      if (state_ff == ST_LOOK) begin
         xsq_ff <= xsq_full;
         ysq_ff <= ysq_full;
         rsq_ff <= {{REG_BITS{1'b0}}, radius_ff} * {{REG_BITS{1'b0}}, radius_ff};
      end
      if (go) begin
         rsp_passed_ff <= res_passed;
         rsp_newly_ff  <= res_newly;
         rsp_over_ff   <= res_over;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_passed         = rsp_passed_ff;
   assign rsp_newly_ignored  = rsp_newly_ff;
   assign rsp_table_overflow = rsp_over_ff;

   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DECIDE)
      else $error("result appeared outside the decide cycle");

   a_newly_not_passed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_newly_ff && rsp_passed_ff))
      else $error("item both passed and newly ignored");

   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOK)
      else $error("accepted item did not enter the compare cycle");

   a_look_to_decide: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOK |=> state_ff == ST_DECIDE)
      else $error("compare cycle not followed by decide");

   a_frame_quiet: assert property (@(posedge clock) disable iff (reset)
      go && !is_obj |=> !rsp_passed_ff && !rsp_newly_ff && !rsp_over_ff)
      else $error("frame start produced a nonzero result");

endmodule
